FILE: rtl/bbr_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 RGB box blur.
`default_nettype none

package bbr_pkg;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 4096;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueueAw      = $clog2(QueueDepth);
  localparam int unsigned QueueCw      = $clog2(QueueDepth + 1);
  localparam int unsigned RecipShift   = 16;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic up;
    logic down;
    logic lft;
    logic rgt;
  } nbr_mask_t;

  typedef struct packed {
    rgb_t [8:0] tap;
    logic [3:0] cnt;
    logic       last;
  } win_t;

  function automatic logic [16:0] recip(input logic [3:0] n);
    logic [16:0] m;
    case (n)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21845;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10922;
      4'd9:    m = 17'd7281;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bbr_fifo.sv
// Short queue of classified windows between the front and the back.
`default_nettype none

module bbr_fifo
  import bbr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  win_t                    data_i,
  input  wire logic               pop_i,
  output win_t                    data_o,
  output logic                    empty_o,
  output logic [QueueCw-1:0]      count_o
);

  win_t               mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCw-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueueAw'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueueAw'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QueueCw'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QueueCw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QueueCw'(QueueDepth)) || pop_i)
    else $error("Window queue written while full.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("Window queue read while empty.");

endmodule

`default_nettype wire

FILE: rtl/bbr_front.sv
// Front end: raster counters, line buffer, 3x3 window and neighbor classification.
`default_nettype none

module bbr_front
  import bbr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               restart_i,
  input  wire logic [11:0]        cfg_width_i,
  input  wire logic [12:0]        cfg_height_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  pix_in_t                 in_data_i,
  input  wire logic [QueueCw-1:0] queue_count_i,
  output logic                    push_o,
  output win_t                    push_data_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [16:0]   w_raw, h_raw;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    w_raw = 17'(cfg_width_i);
    h_raw = 17'(cfg_height_i);
    if (w_raw == 17'd0) begin
      w_raw = 17'd1;
    end else if (w_raw > 17'(MAX_WIDTH)) begin
      w_raw = 17'(MAX_WIDTH);
    end
    if (h_raw == 17'd0) begin
      h_raw = 17'd1;
    end else if (h_raw > 17'(MAX_HEIGHT)) begin
      h_raw = 17'(MAX_HEIGHT);
    end
    eff_w = w_raw[WW-1:0];
    eff_h = h_raw[HW-1:0];
  end

  logic [CW-1:0] in_col_q, in_col_d;
  logic [1:0]    in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;
  logic          s0_valid_q;

  logic accept, emit, col_end, out_col_end, out_row_end, frame_end;
  nbr_mask_t mask;

  assign in_stall_o  = (queue_count_i + QueueCw'(s0_valid_q)) >= QueueCw'(QueueDepth);
  assign accept      = in_valid_i && !in_stall_o;
  assign emit        = (in_row_q == 2'd2) || ((in_row_q == 2'd1) && (in_col_q != '0));
  assign col_end     = (WW'(in_col_q) == eff_w - WW'(1));
  assign out_col_end = (WW'(out_col_q) == eff_w - WW'(1));
  assign out_row_end = (HW'(out_row_q) == eff_h - HW'(1));
  assign frame_end   = emit && out_col_end && out_row_end;

  always_comb begin
    mask.up   = (out_row_q != '0);
    mask.down = !out_row_end;
    mask.lft  = (out_col_q != '0);
    mask.rgt  = !out_col_end;
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept) begin
      if (frame_end) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (emit) begin
          if (out_col_end) begin
            out_col_d = '0;
            out_row_d = out_row_q + RW'(1);
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
        end
        if (col_end) begin
          in_col_d = '0;
          if (in_row_q != 2'd2) begin
            in_row_d = in_row_q + 2'd1;
          end
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
      end
    end
  end

  rgb_t          s0_pix_q, s0_pix_d;
  logic [CW-1:0] s0_addr_q;
  logic          s0_emit_q;
  nbr_mask_t     s0_mask_q;
  logic          s0_last_q;
  logic          s0_byp_q, s0_byp_d;
  logic [47:0]   s0_fwd_q;
  logic [47:0]   rd_q;
  logic [47:0]   line_word, wr_word;
  logic [47:0]   line_mem [MAX_WIDTH];

  always_comb begin
    if (in_data_i.opcode == OP_PIXEL) begin
      s0_pix_d = '{red: in_data_i.red, green: in_data_i.green, blue: in_data_i.blue};
    end else begin
      s0_pix_d = '0;
    end
    s0_byp_d  = s0_valid_q && (s0_addr_q == in_col_q);
    line_word = s0_byp_q ? s0_fwd_q : rd_q;
    wr_word   = {s0_pix_q, line_word[47:24]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      s0_valid_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      s0_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_pix_q  <= s0_pix_d;
      s0_addr_q <= in_col_q;
      s0_emit_q <= emit;
      s0_mask_q <= mask;
      s0_last_q <= frame_end;
      s0_byp_q  <= s0_byp_d;
      s0_fwd_q  <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_valid_q) begin
      line_mem[s0_addr_q] <= wr_word;
    end
    if (accept) begin
      rd_q <= line_mem[in_col_q];
    end
  end

  rgb_t [2:0][2:0] win_q, win_d;
  rgb_t [2:0]      column;
  logic [1:0]      rows_n, cols_n;
  logic            row_ok, col_ok;

  always_comb begin
    column[0] = line_word[23:0];
    column[1] = line_word[47:24];
    column[2] = s0_pix_q;
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
      win_d[r][2] = column[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_valid_q) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    rows_n = 2'd1 + 2'(s0_mask_q.up) + 2'(s0_mask_q.down);
    cols_n = 2'd1 + 2'(s0_mask_q.lft) + 2'(s0_mask_q.rgt);
    push_data_o.cnt  = 4'(rows_n) * 4'(cols_n);
    push_data_o.last = s0_last_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        row_ok = (r == 0) ? s0_mask_q.up : ((r == 2) ? s0_mask_q.down : 1'b1);
        col_ok = (c == 0) ? s0_mask_q.lft : ((c == 2) ? s0_mask_q.rgt : 1'b1);
        push_data_o.tap[3 * r + c] = (row_ok && col_ok) ? win_d[r][c] : '0;
      end
    end
  end

  assign push_o = s0_valid_q && s0_emit_q;

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(in_col_q) < eff_w)
    else $error("Input column counter ran past the image width.");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_end && !restart_i) |=>
      (in_col_q == '0) && (in_row_q == 2'd0) && (out_col_q == '0) && (out_row_q == '0))
    else $error("Counters did not return to zero after the last pixel of a frame.");

endmodule

`default_nettype wire

FILE: rtl/bbr_back.sv
// Back end: window sums, division by the neighbor count with rounding, output register.
`default_nettype none

module bbr_back
  import bbr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic queue_empty_i,
  input  win_t      queue_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output pix_out_t  out_data_o
);

  logic en;

  logic             b1_valid_q;
  logic [2:0][11:0] b1_sum_q, b1_sum_d;
  logic [3:0]       b1_cnt_q;
  logic             b1_last_q;

  logic             b2_valid_q;
  logic [2:0][11:0] b2_sum_q;
  logic [2:0][11:0] b2_q0_q, b2_q0_d;
  logic [3:0]       b2_cnt_q;
  logic             b2_last_q;

  logic             out_valid_q;
  pix_out_t         out_data_q, out_data_d;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !queue_empty_i;

  always_comb begin
    b1_sum_d = '0;
    for (int k = 0; k < 9; k++) begin
      b1_sum_d[0] = b1_sum_d[0] + 12'(queue_data_i.tap[k].red);
      b1_sum_d[1] = b1_sum_d[1] + 12'(queue_data_i.tap[k].green);
      b1_sum_d[2] = b1_sum_d[2] + 12'(queue_data_i.tap[k].blue);
    end
  end

  logic [28:0] prod;

  always_comb begin
    b2_q0_d = '0;
    for (int ch = 0; ch < 3; ch++) begin
      prod        = 29'(b1_sum_q[ch]) * 29'(recip(b1_cnt_q));
      b2_q0_d[ch] = prod[RecipShift +: 12];
    end
  end

  logic [2:0][15:0] rem;
  logic [2:0][11:0] quo;
  logic [15:0]      cnt16;

  always_comb begin
    cnt16 = 16'(b2_cnt_q);
    for (int ch = 0; ch < 3; ch++) begin
      quo[ch] = b2_q0_q[ch];
      rem[ch] = 16'(b2_sum_q[ch]) - 16'(b2_q0_q[ch]) * cnt16;
      if (rem[ch] >= cnt16) begin
        quo[ch] = quo[ch] + 12'd1;
        rem[ch] = rem[ch] - cnt16;
      end
      if (({rem[ch][14:0], 1'b0} > cnt16) ||
          (({rem[ch][14:0], 1'b0} == cnt16) && quo[ch][0])) begin
        quo[ch] = quo[ch] + 12'd1;
      end
    end
    out_data_d.red_out    = quo[0][7:0];
    out_data_d.green_out  = quo[1][7:0];
    out_data_d.blue_out   = quo[2][7:0];
    out_data_d.frame_last = b2_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b1_valid_q  <= pop_o;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_sum_q   <= b1_sum_d;
      b1_cnt_q   <= queue_data_i.cnt;
      b1_last_q  <= queue_data_i.last;
      b2_sum_q   <= b1_sum_q;
      b2_q0_q    <= b2_q0_d;
      b2_cnt_q   <= b1_cnt_q;
      b2_last_q  <= b1_last_q;
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur with its register port.
//
// Pixels of one frame enter on the in channel in raster order, one word per
// pixel (opcode pixel) or per drain tick (opcode drain). Each word advances
// the raster position; the blurred pixel for position q leaves on the out
// channel when position q + width + 1 is accepted, so after the last pixel
// the source sends width + 1 drain words to flush the frame. frame_last marks
// the final pixel of the frame, after which the next word starts a new frame.
// The block takes one word per cycle while in_stall_o is low. On its way to
// the out channel a result passes a line buffer read stage that also forms
// the window, a four-entry queue, a sum stage, a reciprocal multiply stage
// and the output register; the queue sits between window and arithmetic.
// When the receiver stalls, the arithmetic pipeline holds, the queue fills
// and in_stall_o rises once the queue plus the read stage hold four entries.
// Reset clears all counters and sets width 2048 and height 4096. Writing
// either register restarts the frame; write them only while the block is
// idle. Line buffer contents are never cleared, only masked at the borders.
`default_nettype none

module box_blur_3x3_rgb
  import bbr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  pix_in_t          in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pix_out_t         out_data_o
);

  logic [11:0] width_q, width_d;
  logic [12:0] height_q, height_d;
  logic        cfg_write;
  reg_idx_e    reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_write) begin
      case (reg_sel)
        REG_WIDTH:  width_d  = pwdata[11:0];
        REG_HEIGHT: height_d = pwdata[12:0];
        default:    width_d  = width_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = {20'd0, width_q};
      REG_HEIGHT: prdata = {19'd0, height_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd2048;
      height_q <= 13'd4096;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  logic               push, pop, queue_empty;
  logic [QueueCw-1:0] queue_count;
  win_t               push_data, queue_data;

  bbr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_write),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .queue_count_i(queue_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  bbr_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (queue_data),
    .empty_o(queue_empty),
    .count_o(queue_count)
  );

  bbr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_empty_i(queue_empty),
    .queue_data_i (queue_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

FILE: tb/box_blur_3x3_rgb_test.sv
// Self-checking testbench of the streaming 3x3 RGB box blur, with a built-in predictor.
`timescale 1ns / 1ps

module box_blur_3x3_rgb_test;
  import bbr_pkg::*;

  localparam int unsigned MaxW     = MaxWidthDef;
  localparam int unsigned MaxH     = MaxHeightDef;
  localparam int unsigned RingLen  = 2 * MaxW + 3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  pix_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  pix_out_t    out_data_o;

  box_blur_3x3_rgb i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state.
  logic [23:0]  line_ring [RingLen];
  logic [11:0]  cfg_width = 12'd2048;
  logic [12:0]  cfg_height = 13'd4096;
  int unsigned  ring_pos, tick_row, tick_col, pix_row, pix_col;

  pix_in_t  word_feed [$];
  pix_out_t blur_expected [$];
  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned pixels_out = 0;
  int unsigned frames_done = 0;

  function automatic int unsigned width_eff();
    if (cfg_width == 0) return 1;
    if (cfg_width > MaxW) return MaxW;
    return cfg_width;
  endfunction

  function automatic int unsigned height_eff();
    if (cfg_height == 0) return 1;
    if (cfg_height > MaxH) return MaxH;
    return cfg_height;
  endfunction

  function automatic logic [7:0] mean_even(input int unsigned sum, input int unsigned n);
    int unsigned q, r;
    q = sum / n;
    r = sum - q * n;
    if (2 * r > n || (2 * r == n && q[0])) q++;
    return q[7:0];
  endfunction

  task automatic restart_frame();
    ring_pos = 0;
    tick_row = 0;
    tick_col = 0;
    pix_row = 0;
    pix_col = 0;
  endtask

  task automatic blur_step(input pix_in_t word);
    int unsigned w, h, n, back, idx;
    int unsigned s_r, s_g, s_b;
    int rr, cc;
    logic [23:0] v;
    pix_out_t res;
    logic last;
    w = width_eff();
    h = height_eff();
    line_ring[ring_pos] = (word.opcode == OP_PIXEL) ?
                          {word.red, word.green, word.blue} : 24'd0;
    if (tick_row >= 2 || (tick_row == 1 && tick_col >= 1)) begin
      n = 0; s_r = 0; s_g = 0; s_b = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = int'(pix_row) + dr;
          cc = int'(pix_col) + dc;
          if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
            back = int'(w) + 1 - dr * int'(w) - dc;
            idx = (ring_pos + RingLen - back) % RingLen;
            v = line_ring[idx];
            n++;
            s_r += v[23:16];
            s_g += v[15:8];
            s_b += v[7:0];
          end
        end
      end
      if (n == 0) n = 1;
      last = (pix_row + 1 >= h) && (pix_col + 1 >= w);
      res.red_out = mean_even(s_r, n);
      res.green_out = mean_even(s_g, n);
      res.blue_out = mean_even(s_b, n);
      res.frame_last = last;
      blur_expected.push_back(res);
      if (last) begin
        restart_frame();
        return;
      end
      pix_col++;
      if (pix_col >= w) begin
        pix_col = 0;
        pix_row++;
      end
    end
    ring_pos = (ring_pos + 1) % RingLen;
    tick_col++;
    if (tick_col >= w) begin
      tick_col = 0;
      tick_row++;
    end
  endtask

  // Driver: bursts of words with random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (word_feed.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= word_feed.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, plus one long hold-off.
  logic long_hold = 1'b0;
  int unsigned stall_cyc = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= long_hold;
      1: out_stall_i <= long_hold || ($urandom_range(0, 1) == 1);
      2: out_stall_i <= long_hold || (stall_cyc % 3 == 0);
      default: out_stall_i <= long_hold || ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    wait (words_in > 300);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Monitor: predict on accepted input words, check accepted results.
  pix_out_t want;
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      blur_step(in_data_i);
      words_in <= words_in + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (blur_expected.size() == 0) begin
        $error("unexpected output word %h", out_data_o);
        errors++;
      end else begin
        want = blur_expected.pop_front();
        if (out_data_o.red_out !== want.red_out) begin
          $error("red_out: expected %0d, actual %0d", want.red_out, out_data_o.red_out);
          errors++;
        end
        if (out_data_o.green_out !== want.green_out) begin
          $error("green_out: expected %0d, actual %0d", want.green_out,
                 out_data_o.green_out);
          errors++;
        end
        if (out_data_o.blue_out !== want.blue_out) begin
          $error("blue_out: expected %0d, actual %0d", want.blue_out, out_data_o.blue_out);
          errors++;
        end
        if (out_data_o.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0d, actual %0d", want.frame_last,
                 out_data_o.frame_last);
          errors++;
        end
        pixels_out++;
        if (want.frame_last) frames_done++;
      end
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_WIDTH) cfg_width = value[11:0];
    else cfg_height = value[12:0];
    restart_frame();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (word_feed.size() == 0 && !in_valid_i && blur_expected.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [31:0] w, input logic [31:0] h);
    wait_idle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  function automatic pix_in_t make_word(input opcode_e op, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
    pix_in_t p;
    p.opcode = op;
    p.red = r;
    p.green = g;
    p.blue = b;
    return p;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One random frame: pixels with a few early drains, then the flush ticks.
  task automatic random_frame();
    int unsigned w, h;
    opcode_e op;
    w = width_eff();
    h = height_eff();
    for (int unsigned i = 0; i < w * h; i++) begin
      op = ($urandom_range(0, 15) == 0) ? OP_DRAIN : OP_PIXEL;
      word_feed.push_back(make_word(op, rand_chan(), rand_chan(), rand_chan()));
    end
    for (int unsigned i = 0; i <= w; i++) begin
      op = ($urandom_range(0, 7) == 0) ? OP_PIXEL : OP_DRAIN;
      word_feed.push_back(make_word(op, rand_chan(), rand_chan(), rand_chan()));
    end
  endtask

  int unsigned queued;
  initial begin
    restart_frame();
    for (int i = 0; i < RingLen; i++) line_ring[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed 3x3 frame: extremes, one early drain, an extra pixel in the flush.
    set_size(3, 3);
    word_feed.push_back(make_word(OP_PIXEL, 8'd255, 8'd255, 8'd255));
    word_feed.push_back(make_word(OP_PIXEL, 8'd0, 8'd0, 8'd0));
    word_feed.push_back(make_word(OP_PIXEL, 8'd255, 8'd0, 8'd170));
    word_feed.push_back(make_word(OP_PIXEL, 8'd0, 8'd255, 8'd85));
    word_feed.push_back(make_word(OP_DRAIN, 8'd255, 8'd255, 8'd255));
    word_feed.push_back(make_word(OP_PIXEL, 8'd1, 8'd2, 8'd3));
    word_feed.push_back(make_word(OP_PIXEL, 8'd255, 8'd255, 8'd254));
    word_feed.push_back(make_word(OP_PIXEL, 8'd128, 8'd127, 8'd129));
    word_feed.push_back(make_word(OP_PIXEL, 8'd255, 8'd255, 8'd255));
    word_feed.push_back(make_word(OP_DRAIN, 8'd0, 8'd0, 8'd0));
    word_feed.push_back(make_word(OP_PIXEL, 8'd77, 8'd66, 8'd55));
    word_feed.push_back(make_word(OP_DRAIN, 8'd0, 8'd0, 8'd0));
    word_feed.push_back(make_word(OP_DRAIN, 8'd0, 8'd0, 8'd0));
    // A zero size acts as one pixel.
    set_size(0, 0);
    word_feed.push_back(make_word(OP_PIXEL, 8'd200, 8'd100, 8'd50));
    word_feed.push_back(make_word(OP_DRAIN, 8'd0, 8'd0, 8'd0));
    word_feed.push_back(make_word(OP_DRAIN, 8'd0, 8'd0, 8'd0));

    queued = 0;
    while (queued < 850) begin
      if ($urandom_range(0, 9) == 0) set_size($urandom_range(1, 64), $urandom_range(1, 4));
      else set_size($urandom_range(1, 8), $urandom_range(1, 6));
      repeat ($urandom_range(1, 3)) begin
        queued += width_eff() * height_eff() + width_eff() + 1;
        random_frame();
      end
    end

    wait_idle();
    if (blur_expected.size() != 0) begin
      $error("%0d expected output words never arrived", blur_expected.size());
      errors++;
    end
    $display("Run covered %0d input words and %0d blurred pixels in %0d frames.",
             words_in, pixels_out, frames_done);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d output words outstanding.", blur_expected.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
